### rtl/i2crs_pkg.sv
// Shared types, command codes and the CRC-8 step for the I2C register slave.
// No dependencies; imported by i2c_register_slave_crc8_core.
`default_nettype none

package i2crs_pkg;

    // Number of value slots held by the slave.
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    // Bus event codes.
    localparam logic [2:0] OP_WRITE_ADDR = 3'd0;
    localparam logic [2:0] OP_DATA       = 3'd1;
    localparam logic [2:0] OP_READ       = 3'd2;
    localparam logic [2:0] OP_BUS_ERROR  = 3'd3;
    localparam logic [2:0] OP_LOAD_SLOT  = 3'd4;

    // Setter commands.
    localparam logic [7:0] CMD_BACKLIGHT_SET = 8'h87;
    localparam logic [7:0] CMD_SWITCH_FIRST  = 8'h8D;
    localparam logic [7:0] CMD_SWITCH_LAST   = 8'h91;
    localparam logic [7:0] CMD_BUZZER_SET    = 8'h92;
    localparam logic [7:0] CMD_FAN_SET       = 8'h93;
    localparam logic [7:0] CMD_RED_SET       = 8'h94;
    localparam logic [7:0] CMD_GREEN_SET     = 8'h95;
    localparam logic [7:0] CMD_BLUE_SET      = 8'h96;

    // Read commands.
    localparam logic [7:0] CMD_SLOT_LOW_LAST  = 8'h06;
    localparam logic [7:0] CMD_BACKLIGHT_READ = 8'h07;
    localparam logic [7:0] CMD_SLOT_HIGH_LAST = 8'h0B;
    localparam logic [7:0] CMD_LED_READ       = 8'h0C;
    localparam logic [7:0] CMD_SWITCH_READ    = 8'h0D;
    localparam logic [7:0] CMD_SWITCH_RD_LAST = 8'h10;
    localparam logic [7:0] CMD_HEATER_READ    = 8'h11;
    localparam logic [7:0] CMD_BUZZER_READ    = 8'h12;
    localparam logic [7:0] CMD_FAN_READ       = 8'h13;
    localparam logic [7:0] CMD_SLOT7_ALIAS    = 8'h14;
    localparam logic [7:0] CMD_NONE           = 8'hFF;

    // Slots and byte values with a special meaning.
    localparam logic [7:0] SLOT_ALIAS_TARGET = 8'h07;
    localparam logic [3:0] SLOT_BACKLIGHT    = 4'd12;
    localparam logic [7:0] BYTE_ON           = 8'hFF;
    localparam logic [7:0] BYTE_OFF          = 8'h00;
    localparam logic [7:0] BUZZ_PULSE_REQ    = 8'h01;
    localparam logic [7:0] BUZZ_PULSE_MARK   = 8'h02;

    // Byte pointer values.
    localparam logic [7:0] PTR_IDLE       = 8'hFF;
    localparam logic [7:0] PTR_HEATER_END = 8'hFE;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // Configuration register map (byte address bits above the word offset).
    localparam int         CFG_ADDR_W       = 3;
    localparam logic [0:0] REG_ERROR_LIMIT  = 1'b0;
    localparam logic [7:0] ERROR_LIMIT_INIT = 8'd50;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data_byte;
        logic [3:0]  slot_index;
        logic [15:0] slot_value;
        logic        heater_pin_level;
    } evt_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [5:0] switch_outputs;
        logic       buzzer_pulse;
        logic [7:0] fan_compare;
        logic [7:0] backlight_target;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic       led_changed;
        logic [7:0] error_count;
        logic       slave_reinit;
    } res_t;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic is_setter(input logic [7:0] c);
        return (c == CMD_BACKLIGHT_SET) || ((c >= CMD_SWITCH_FIRST) && (c <= CMD_BLUE_SET));
    endfunction

    function automatic logic is_slot_cmd(input logic [7:0] c);
        return (c <= CMD_SLOT_LOW_LAST)
            || ((c > CMD_BACKLIGHT_READ) && (c <= CMD_SLOT_HIGH_LAST))
            || (c == CMD_SLOT7_ALIAS);
    endfunction

endpackage

`default_nettype wire

### rtl/i2c_register_slave_crc8_core.sv
// I2C register slave with CRC-8 checked writes; depends on i2crs_pkg.
// An accepted item passes the input stage and then the result stage before its result is valid.
// Throughput: one item per cycle while results are taken without stall.
// While a finished result waits, the input stage takes one more item and then stalls.
// Reset (rst_n low, asynchronous) returns every state register and slot to its default at once;
// there is no clearing pass, and items are taken as soon as reset is released.
`default_nettype none

module i2c_register_slave_crc8_core (
    input  wire                              clk,
    input  wire                              rst_n,
    // Bus event channel
    input  wire                              evt_valid,
    output logic                             evt_ready,
    input  wire  i2crs_pkg::evt_t            evt,
    // Result channel
    output logic                             res_valid,
    input  wire                              res_ready,
    output i2crs_pkg::res_t                  res,
    // Configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [i2crs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import i2crs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration: a single error limit register at word 0.
    // ------------------------------------------------------------------
    logic [7:0] error_limit_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ERROR_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_limit_reg <= ERROR_LIMIT_INIT;
        end
        else if (cfg_write)
        begin
            error_limit_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ERROR_LIMIT)
        begin
            prdata = {24'd0, error_limit_reg};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input stage holds one item; it moves into the
    // result register whenever that register is empty or being drained.
    // ------------------------------------------------------------------
    evt_t stg_item_reg;
    logic stg_valid_reg;
    res_t res_item_reg;
    res_t res_item_next;
    logic res_valid_reg;
    logic res_load;

    assign res_load  = stg_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !stg_valid_reg || res_load;
    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_ready)
            begin
                stg_valid_reg <= evt_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            stg_item_reg <= evt;
        end
        if (res_load)
        begin
            res_item_reg <= res_item_next;
        end
    end

    // ------------------------------------------------------------------
    // Slave state.
    // ------------------------------------------------------------------
    logic [7:0]  command_reg,  command_next;
    logic [7:0]  pointer_reg,  pointer_next;
    logic [7:0]  crc_reg,      crc_next;
    logic [7:0]  latched_reg,  latched_next;
    logic [15:0] read_word_reg, read_word_next;
    logic [7:0]  cur_bl_reg,   cur_bl_next;
    logic [5:0]  switch_reg,   switch_next;
    logic [7:0]  fan_reg,      fan_next;
    logic [7:0]  bl_goal_reg,  bl_goal_next;
    logic [7:0]  led_reg [3];
    logic [7:0]  led_next [3];
    logic [7:0]  err_cnt_reg,  err_cnt_next;
    logic [15:0] slot_reg [SLOT_COUNT];

    logic              slot_we;
    logic [SLOT_W-1:0] slot_widx;
    logic [SLOT_W-1:0] slot_ridx;

    // Working signals of the item decode.
    logic       count_err;
    logic       pulse;
    logic       led_chg;
    logic       reinit;
    logic [7:0] tx;
    logic [7:0] cmd_off;
    logic [7:0] one_val;
    logic       one_hit;
    logic       heater_cmd;
    logic [7:0] pick;

    // The slot picked by a command byte; 0x14 stands for slot 7.
    assign slot_ridx = (stg_item_reg.data_byte == CMD_SLOT7_ALIAS)
                     ? SLOT_ALIAS_TARGET[SLOT_W-1:0]
                     : stg_item_reg.data_byte[SLOT_W-1:0];

    always_comb
    begin
        command_next   = command_reg;
        pointer_next   = pointer_reg;
        crc_next       = crc_reg;
        latched_next   = latched_reg;
        read_word_next = read_word_reg;
        cur_bl_next    = cur_bl_reg;
        switch_next    = switch_reg;
        fan_next       = fan_reg;
        bl_goal_next   = bl_goal_reg;
        led_next       = led_reg;
        err_cnt_next   = err_cnt_reg;
        slot_we        = 1'b0;
        slot_widx      = SLOT_W'(stg_item_reg.slot_index);
        count_err      = 1'b0;
        pulse          = 1'b0;
        led_chg        = 1'b0;
        reinit         = 1'b0;
        tx             = BYTE_ON;
        cmd_off        = 8'd0;
        one_val        = BYTE_OFF;
        one_hit        = 1'b0;
        heater_cmd     = 1'b0;
        pick           = BYTE_OFF;

        case (stg_item_reg.op)
            OP_WRITE_ADDR:
            begin
                pointer_next = PTR_IDLE;
            end

            OP_DATA:
            begin
                if (pointer_reg == PTR_IDLE)
                begin
                    // First byte of a write transaction is the command.
                    command_next = stg_item_reg.data_byte;
                    crc_next     = crc8_step(8'd0, stg_item_reg.data_byte);
                    pointer_next = 8'd0;
                    err_cnt_next = 8'd0;
                    if (is_slot_cmd(stg_item_reg.data_byte))
                    begin
                        read_word_next = slot_reg[slot_ridx];
                    end
                end
                else
                begin
                    if (pointer_reg == 8'd0)
                    begin
                        latched_next = stg_item_reg.data_byte;
                        crc_next     = crc8_step(crc_reg, stg_item_reg.data_byte);
                    end
                    else if ((pointer_reg == 8'd1) && (stg_item_reg.data_byte == crc_reg))
                    begin
                        // The CRC matched: the setter takes effect.
                        if (command_reg == CMD_BACKLIGHT_SET)
                        begin
                            bl_goal_next = latched_reg;
                        end
                        else if ((command_reg >= CMD_SWITCH_FIRST) &&
                                 (command_reg <= CMD_SWITCH_LAST))
                        begin
                            cmd_off = command_reg - CMD_SWITCH_FIRST;
                            switch_next[cmd_off[2:0]] = (latched_reg == BYTE_ON);
                        end
                        else if (command_reg == CMD_BUZZER_SET)
                        begin
                            if (latched_reg == BYTE_ON)
                            begin
                                switch_next[5] = 1'b1;
                            end
                            else if (latched_reg == BUZZ_PULSE_REQ)
                            begin
                                switch_next[5] = 1'b1;
                                latched_next   = BUZZ_PULSE_MARK;
                            end
                            else
                            begin
                                switch_next[5] = 1'b0;
                                latched_next   = BYTE_OFF;
                            end
                        end
                        else if (command_reg == CMD_FAN_SET)
                        begin
                            fan_next = latched_reg;
                        end
                        else if ((command_reg >= CMD_RED_SET) && (command_reg <= CMD_BLUE_SET))
                        begin
                            cmd_off = command_reg - CMD_RED_SET;
                            led_next[cmd_off[1:0]] = latched_reg;
                            led_chg = 1'b1;
                        end
                        else
                        begin
                            count_err = 1'b1;
                        end
                    end
                    else
                    begin
                        count_err = 1'b1;
                    end
                    pointer_next = pointer_reg + 8'd1;
                end

                // A pulse request is served at once: the buzzer goes low again.
                if ((command_next == CMD_BUZZER_SET) && (latched_next == BUZZ_PULSE_MARK))
                begin
                    switch_next[5] = 1'b0;
                    pulse          = 1'b1;
                end
            end

            OP_READ:
            begin
                if (is_setter(command_reg))
                begin
                    tx       = crc_reg;
                    crc_next = BYTE_ON;
                end
                else if (is_slot_cmd(command_reg))
                begin
                    if (pointer_reg <= 8'd1)
                    begin
                        tx = (pointer_reg == 8'd0) ? read_word_reg[7:0] : read_word_reg[15:8];
                        crc_next = crc8_step(crc_reg, tx);
                    end
                    else if (pointer_reg == 8'd2)
                    begin
                        tx = crc_reg;
                    end
                    else
                    begin
                        count_err = 1'b1;
                    end
                end
                else if (command_reg == CMD_LED_READ)
                begin
                    if (pointer_reg <= 8'd2)
                    begin
                        tx       = led_reg[pointer_reg[1:0]];
                        crc_next = crc8_step(crc_reg, tx);
                    end
                    else if (pointer_reg == 8'd3)
                    begin
                        tx = crc_reg;
                    end
                    else
                    begin
                        count_err = 1'b1;
                    end
                end
                else
                begin
                    // Single-byte readbacks followed by their CRC.
                    if (command_reg == CMD_BACKLIGHT_READ)
                    begin
                        one_hit = 1'b1;
                        one_val = cur_bl_reg;
                    end
                    else if ((command_reg >= CMD_SWITCH_READ) &&
                             (command_reg <= CMD_SWITCH_RD_LAST))
                    begin
                        one_hit = 1'b1;
                        cmd_off = command_reg - CMD_SWITCH_READ;
                        one_val = switch_reg[cmd_off[1:0]] ? BYTE_ON : BYTE_OFF;
                    end
                    else if (command_reg == CMD_HEATER_READ)
                    begin
                        one_hit    = 1'b1;
                        heater_cmd = 1'b1;
                        one_val    = stg_item_reg.heater_pin_level ? BYTE_ON : BYTE_OFF;
                    end
                    else if (command_reg == CMD_BUZZER_READ)
                    begin
                        one_hit = 1'b1;
                        one_val = switch_reg[5] ? BYTE_ON : BYTE_OFF;
                    end
                    else if (command_reg == CMD_FAN_READ)
                    begin
                        one_hit = 1'b1;
                        one_val = fan_reg;
                    end

                    if (one_hit)
                    begin
                        if (pointer_reg == 8'd0)
                        begin
                            tx       = one_val;
                            crc_next = crc8_step(crc_reg, one_val);
                        end
                        else if (pointer_reg == 8'd1)
                        begin
                            tx = crc_reg;
                        end
                        else
                        begin
                            count_err = 1'b1;
                        end
                    end
                end

                // The heater readback parks the pointer so that it steps to idle.
                pick = (heater_cmd && (pointer_reg > 8'd1)) ? PTR_HEATER_END : pointer_reg;
                pointer_next = pick + 8'd1;
            end

            OP_BUS_ERROR:
            begin
                count_err = 1'b1;
            end

            OP_LOAD_SLOT:
            begin
                if (32'(stg_item_reg.slot_index) < SLOT_COUNT)
                begin
                    slot_we = 1'b1;
                    if (stg_item_reg.slot_index == SLOT_BACKLIGHT)
                    begin
                        cur_bl_next = stg_item_reg.slot_value[7:0];
                    end
                end
            end

            default:
            begin
                // Unused event codes leave the state alone.
            end
        endcase

        // The error counter saturates.
        if (count_err && (err_cnt_next != 8'hFF))
        begin
            err_cnt_next = err_cnt_next + 8'd1;
        end

        // Too many errors: the slave drops its transaction and starts over.
        if (err_cnt_next > error_limit_reg)
        begin
            pointer_next = PTR_IDLE;
            err_cnt_next = 8'd0;
            reinit       = 1'b1;
        end

        res_item_next.tx_byte          = tx;
        res_item_next.switch_outputs   = switch_next;
        res_item_next.buzzer_pulse     = pulse;
        res_item_next.fan_compare      = fan_next;
        res_item_next.backlight_target = bl_goal_next;
        res_item_next.led_red          = led_next[0];
        res_item_next.led_green        = led_next[1];
        res_item_next.led_blue         = led_next[2];
        res_item_next.led_changed      = led_chg;
        res_item_next.error_count      = err_cnt_next;
        res_item_next.slave_reinit     = reinit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg   <= CMD_NONE;
            pointer_reg   <= PTR_IDLE;
            crc_reg       <= 8'd0;
            latched_reg   <= 8'd0;
            read_word_reg <= 16'd0;
            cur_bl_reg    <= 8'd31;
            switch_reg    <= 6'd0;
            fan_reg       <= 8'd215;
            bl_goal_reg   <= 8'd31;
            err_cnt_reg   <= 8'd0;
            for (int i = 0; i < 3; i++)
            begin
                led_reg[i] <= 8'd0;
            end
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= 16'd0;
            end
        end
        else if (res_load)
        begin
            command_reg   <= command_next;
            pointer_reg   <= pointer_next;
            crc_reg       <= crc_next;
            latched_reg   <= latched_next;
            read_word_reg <= read_word_next;
            cur_bl_reg    <= cur_bl_next;
            switch_reg    <= switch_next;
            fan_reg       <= fan_next;
            bl_goal_reg   <= bl_goal_next;
            err_cnt_reg   <= err_cnt_next;
            led_reg       <= led_next;
            if (slot_we)
            begin
                slot_reg[slot_widx] <= stg_item_reg.slot_value;
            end
        end
    end

`ifndef ASSERT_OFF
    // An item waiting in the input stage is never dropped.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !res_load) |=> stg_valid_reg)
        else $error("input stage lost an item");

    // A buzzer pulse always leaves the buzzer low in the same result.
    a_pulse_low: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.buzzer_pulse) |-> !res_item_reg.switch_outputs[5])
        else $error("buzzer high after pulse");

    // An LED change only comes from an LED setter command.
    a_led_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && led_chg) |->
        (command_reg == CMD_RED_SET || command_reg == CMD_GREEN_SET ||
         command_reg == CMD_BLUE_SET))
        else $error("LED changed by a non-LED command");

    // Reinitialization clears the error count and parks the pointer.
    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && reinit) |=> (err_cnt_reg == 8'd0) && (pointer_reg == PTR_IDLE))
        else $error("reinit did not clear the slave");
`endif

endmodule

`default_nettype wire

### tb/i2c_slave_result_checker.sv
// Result checker for the I2C register slave: predicts one status item per bus event
// and compares it with what the block returns. Depends on i2crs_pkg for the item types.
module i2c_slave_result_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             evt_valid,
    input  wire                             evt_ready,
    input  i2crs_pkg::evt_t                 evt,
    input  wire                             res_valid,
    input  wire                             res_ready,
    input  i2crs_pkg::res_t                 res,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [i2crs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [31:0]                      pwdata,
    input  wire                             pready,
    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2crs_pkg::*;

    localparam int         BUZZER_BIT     = 5;
    localparam int         PRINT_CAP      = 40;
    localparam logic [7:0] NO_DATA        = 8'hFF;
    localparam logic [7:0] CRC_CLOSED     = 8'hFF;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] BACKLIGHT_INIT = 8'd31;
    localparam logic [7:0] FAN_INIT       = 8'd215;

    // Shadow of the slave's registers.
    logic [7:0]  limit_q;
    logic [7:0]  cmd_q;
    logic [7:0]  ptr_q;
    logic [7:0]  crc_q;
    logic [7:0]  latch_q;
    logic [15:0] word_q;
    logic [15:0] slot_mem [SLOT_COUNT];
    logic [7:0]  bl_level_q;
    logic [5:0]  sw_q;
    logic [7:0]  fan_q;
    logic [7:0]  bl_goal_q;
    logic [7:0]  led_q [3];
    logic [7:0]  err_q;

    res_t status_due [$];
    int   results_seen;

    initial mismatches = 0;

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        repeat (8)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic setter_cmd(logic [7:0] c);
        return c == CMD_BACKLIGHT_SET || (c >= CMD_SWITCH_FIRST && c <= CMD_BLUE_SET);
    endfunction

    function automatic logic slot_cmd(logic [7:0] c);
        return c <= CMD_SLOT_LOW_LAST || (c > CMD_BACKLIGHT_READ && c <= CMD_SLOT_HIGH_LAST)
            || c == CMD_SLOT7_ALIAS;
    endfunction

    function automatic void bump_errors();
        if (err_q != COUNT_MAX)
            err_q = err_q + 8'd1;
    endfunction

    function automatic void set_switch(int bit_no, logic on);
        sw_q[bit_no] = on;
    endfunction

    task automatic clear_model();
        limit_q    = ERROR_LIMIT_INIT;
        cmd_q      = CMD_NONE;
        ptr_q      = PTR_IDLE;
        crc_q      = 8'h00;
        latch_q    = 8'h00;
        word_q     = 16'h0000;
        bl_level_q = BACKLIGHT_INIT;
        sw_q       = 6'd0;
        fan_q      = FAN_INIT;
        bl_goal_q  = BACKLIGHT_INIT;
        err_q      = 8'd0;
        foreach (slot_mem[i])
            slot_mem[i] = 16'h0000;
        foreach (led_q[i])
            led_q[i] = 8'h00;
    endtask

    // Returns 0 when the command is not a known setter.
    function automatic logic commit_setter(output logic led_hit);
        logic [7:0] c;
        logic [7:0] v;
        c = cmd_q;
        v = latch_q;
        led_hit = 1'b0;
        if (c == CMD_BACKLIGHT_SET)
            bl_goal_q = v;
        else if (c >= CMD_SWITCH_FIRST && c <= CMD_SWITCH_LAST)
            set_switch(int'(c - CMD_SWITCH_FIRST), v == BYTE_ON);
        else if (c == CMD_BUZZER_SET)
        begin
            if (v == BYTE_ON)
                set_switch(BUZZER_BIT, 1'b1);
            else if (v == BUZZ_PULSE_REQ)
            begin
                set_switch(BUZZER_BIT, 1'b1);
                latch_q = BUZZ_PULSE_MARK;
            end
            else
            begin
                set_switch(BUZZER_BIT, 1'b0);
                latch_q = BYTE_OFF;
            end
        end
        else if (c == CMD_FAN_SET)
            fan_q = v;
        else if (c >= CMD_RED_SET && c <= CMD_BLUE_SET)
        begin
            led_q[int'(c - CMD_RED_SET)] = v;
            led_hit = 1'b1;
        end
        else
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void take_byte(logic [7:0] d, output logic pulse, output logic led_hit);
        pulse   = 1'b0;
        led_hit = 1'b0;
        if (ptr_q == PTR_IDLE)
        begin
            cmd_q = d;
            crc_q = crc8_next(8'h00, d);
            ptr_q = 8'd0;
            err_q = 8'd0;
            if (slot_cmd(d))
                word_q = slot_mem[(d == CMD_SLOT7_ALIAS) ? SLOT_ALIAS_TARGET[SLOT_W-1:0]
                                                         : d[SLOT_W-1:0]];
        end
        else
        begin
            if (ptr_q == 8'd0)
            begin
                latch_q = d;
                crc_q   = crc8_next(crc_q, d);
            end
            else if (ptr_q == 8'd1 && d == crc_q)
            begin
                if (!commit_setter(led_hit))
                    bump_errors();
            end
            else
                bump_errors();
            ptr_q = ptr_q + 8'd1;
        end
        if (cmd_q == CMD_BUZZER_SET && latch_q == BUZZ_PULSE_MARK)
        begin
            set_switch(BUZZER_BIT, 1'b0);
            pulse = 1'b1;
        end
    endfunction

    // Value byte, then the CRC, then nothing valid.
    function automatic logic [7:0] short_read(logic [7:0] value, logic heater);
        if (ptr_q == 8'd0)
        begin
            crc_q = crc8_next(crc_q, value);
            return value;
        end
        if (ptr_q == 8'd1)
            return crc_q;
        if (heater)
            ptr_q = PTR_HEATER_END;
        bump_errors();
        return NO_DATA;
    endfunction

    function automatic logic [7:0] serve_read(logic heater);
        logic [7:0] c;
        logic [7:0] t;
        c = cmd_q;
        if (setter_cmd(c))
        begin
            t     = crc_q;
            crc_q = CRC_CLOSED;
        end
        else if (slot_cmd(c))
        begin
            if (ptr_q <= 8'd1)
            begin
                t     = (ptr_q == 8'd0) ? word_q[7:0] : word_q[15:8];
                crc_q = crc8_next(crc_q, t);
            end
            else if (ptr_q == 8'd2)
                t = crc_q;
            else
            begin
                t = NO_DATA;
                bump_errors();
            end
        end
        else if (c == CMD_LED_READ)
        begin
            if (ptr_q <= 8'd2)
            begin
                t     = led_q[ptr_q[1:0]];
                crc_q = crc8_next(crc_q, t);
            end
            else if (ptr_q == 8'd3)
                t = crc_q;
            else
            begin
                t = NO_DATA;
                bump_errors();
            end
        end
        else if (c == CMD_BACKLIGHT_READ)
            t = short_read(bl_level_q, 1'b0);
        else if (c >= CMD_SWITCH_READ && c <= CMD_SWITCH_RD_LAST)
            t = short_read(sw_q[int'(c - CMD_SWITCH_READ)] ? BYTE_ON : BYTE_OFF, 1'b0);
        else if (c == CMD_HEATER_READ)
            t = short_read(heater ? BYTE_ON : BYTE_OFF, 1'b1);
        else if (c == CMD_BUZZER_READ)
            t = short_read(sw_q[BUZZER_BIT] ? BYTE_ON : BYTE_OFF, 1'b0);
        else if (c == CMD_FAN_READ)
            t = short_read(fan_q, 1'b0);
        else
            t = NO_DATA;
        ptr_q = ptr_q + 8'd1;
        return t;
    endfunction

    // Advances the shadow by one bus event and returns the status it should produce.
    function automatic res_t apply_bus_event(evt_t e);
        res_t       r;
        logic [7:0] tx;
        logic       pulse;
        logic       led_hit;
        tx      = NO_DATA;
        pulse   = 1'b0;
        led_hit = 1'b0;
        case (e.op)
            OP_WRITE_ADDR: ptr_q = PTR_IDLE;
            OP_DATA:       take_byte(e.data_byte, pulse, led_hit);
            OP_READ:       tx = serve_read(e.heater_pin_level);
            OP_BUS_ERROR:  bump_errors();
            OP_LOAD_SLOT:
            begin
                if (int'(e.slot_index) < SLOT_COUNT)
                begin
                    slot_mem[e.slot_index] = e.slot_value;
                    if (e.slot_index == SLOT_BACKLIGHT)
                        bl_level_q = e.slot_value[7:0];
                end
            end
            default: ;
        endcase
        r.slave_reinit = 1'b0;
        if (err_q > limit_q)
        begin
            ptr_q          = PTR_IDLE;
            err_q          = 8'd0;
            r.slave_reinit = 1'b1;
        end
        r.tx_byte          = tx;
        r.switch_outputs   = sw_q;
        r.buzzer_pulse     = pulse;
        r.fan_compare      = fan_q;
        r.backlight_target = bl_goal_q;
        r.led_red          = led_q[0];
        r.led_green        = led_q[1];
        r.led_blue         = led_q[2];
        r.led_changed      = led_hit;
        r.error_count      = err_q;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic compare_status(res_t want, res_t got);
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("switch_outputs", want.switch_outputs, got.switch_outputs);
        compare_field("buzzer_pulse", want.buzzer_pulse, got.buzzer_pulse);
        compare_field("fan_compare", want.fan_compare, got.fan_compare);
        compare_field("backlight_target", want.backlight_target, got.backlight_target);
        compare_field("led_red", want.led_red, got.led_red);
        compare_field("led_green", want.led_green, got.led_green);
        compare_field("led_blue", want.led_blue, got.led_blue);
        compare_field("led_changed", want.led_changed, got.led_changed);
        compare_field("error_count", want.error_count, got.error_count);
        compare_field("slave_reinit", want.slave_reinit, got.slave_reinit);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            status_due.delete();
            results_seen = 0;
            outstanding  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[CFG_ADDR_W-1:2] == REG_ERROR_LIMIT)
                limit_q = pwdata[7:0];
            // A result can never belong to the item accepted at the same edge.
            if (res_valid && res_ready)
            begin
                if (status_due.size() == 0)
                    report_mismatch($sformatf("no item pending for result 0x%0h", res));
                else
                    compare_status(status_due.pop_front(), res);
                results_seen++;
            end
            if (evt_valid && evt_ready)
                status_due.push_back(apply_bus_event(evt));
            outstanding = status_due.size();
        end
    end

endmodule

### tb/tb_i2c_register_slave_crc8_core.sv
// Top of the I2C register slave testbench: clock, reset, bus event stimulus, result stalls
// and configuration writes. Depends on i2crs_pkg, the core and i2c_slave_result_checker.
module tb_i2c_register_slave_crc8_core;
    timeunit 1ns;
    timeprecision 1ps;
    import i2crs_pkg::*;

    localparam int         ITEM_TARGET = 1800;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         MAX_WAIT    = 8;
    // Cycles waited after the last predicted result has come back, to catch any stray result.
    localparam int         SETTLE      = 8;
    localparam logic [2:0] OP_SPARE    = 3'd7;
    // A command byte that no read or setter decodes.
    localparam logic [7:0] CMD_UNKNOWN = 8'h50;

    logic                  clk;
    logic                  rst_n;
    logic                  evt_valid;
    logic                  evt_ready;
    evt_t                  evt;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fails;
    int pending;
    int items_sent;
    int cycles;
    // While set, neither side inserts wait cycles, so items go back to back.
    bit calm;

    i2c_register_slave_crc8_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // The checker watches both channels and the configuration port on its own;
    // the top only reads back how many results are still due and how many failed.
    i2c_slave_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (fails),
        .outstanding (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_i2c_register_slave_crc8_core: FAIL");
            $finish;
        end
    end

    // Result side: before every result it draws a stall, then holds ready high until
    // the result is taken. Stalls also land while the core has nothing to send.
    initial
    begin : result_sink
        int stall;
        res_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // The CRC that a master appends to a command and its data byte.
    function automatic logic [7:0] crc8_of(logic [7:0] crc, logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        repeat (8)
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    // Every field is random apart from the op and the data byte, so that all payload
    // bits toggle even on events that ignore them.
    function automatic evt_t make_event(logic [2:0] op, logic [7:0] data);
        evt_t e;
        e.op               = op;
        e.data_byte        = data;
        e.slot_index       = 4'($urandom_range(0, 15));
        e.slot_value       = 16'($urandom);
        e.heater_pin_level = 1'($urandom_range(0, 1));
        return e;
    endfunction

    function automatic logic [7:0] setter_code();
        int idx;
        idx = $urandom_range(0, 10);
        return (idx == 0) ? CMD_BACKLIGHT_SET : CMD_SWITCH_FIRST + 8'(idx - 1);
    endfunction

    // Data bytes that the setters treat specially come up often.
    function automatic logic [7:0] data_choice();
        case ($urandom_range(0, 5))
            0:       return BYTE_ON;
            1:       return BYTE_OFF;
            2:       return BUZZ_PULSE_REQ;
            3:       return BUZZ_PULSE_MARK;
            default: return 8'($urandom);
        endcase
    endfunction

    // Presents one item after a random gap and returns at the edge that accepts it.
    // Valid stays high afterwards; the next call lowers it or replaces the payload at
    // the very next falling edge, so an item is never taken twice.
    task automatic send(evt_t e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= e;
        @(posedge clk);
        while (!evt_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] data);
        send(make_event(op, data));
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        @(negedge clk);
        evt_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Setter transaction: command, data byte, CRC byte, then any surplus bytes.
    // Fewer than two bytes after the command leaves the transaction broken off.
    task automatic setter_write(logic [7:0] cmd, logic [7:0] data, bit good_crc,
                                int bytes_after);
        logic [7:0] seal;
        seal = crc8_of(crc8_of(8'h00, cmd), data);
        send_op(OP_WRITE_ADDR, 8'($urandom));
        send_op(OP_DATA, cmd);
        if (bytes_after > 0)
            send_op(OP_DATA, data);
        if (bytes_after > 1)
            send_op(OP_DATA, good_crc ? seal : seal ^ 8'($urandom_range(1, 255)));
        for (int i = 2; i < bytes_after; i++)
            send_op(OP_DATA, 8'($urandom));
    endtask

    // Read transaction: command byte, then a run of read requests that may go past the end.
    task automatic read_back(logic [7:0] cmd, int reads);
        send_op(OP_WRITE_ADDR, 8'($urandom));
        send_op(OP_DATA, cmd);
        repeat (reads)
            send_op(OP_READ, 8'($urandom));
    endtask

    task automatic write_error_limit(logic [7:0] lim);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ERROR_LIMIT, 2'b00};
        pwdata  <= {24'h000000, lim};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Short directed opening: slot loads at the extremes, a backlight setter,
    // the buzzer pulse request, the slot 7 alias read past its end, the heater read
    // past its end, a bus error and an unused op.
    task automatic run_directed();
        evt_t e;
        e = make_event(OP_LOAD_SLOT, 8'h00);
        e.slot_index = 4'd0;
        e.slot_value = 16'hFFFF;
        send(e);
        e = make_event(OP_LOAD_SLOT, 8'hFF);
        e.slot_index = SLOT_BACKLIGHT;
        e.slot_value = 16'h00A5;
        send(e);
        e = make_event(OP_LOAD_SLOT, 8'h00);
        e.slot_index = SLOT_ALIAS_TARGET[3:0];
        e.slot_value = 16'h8001;
        send(e);
        setter_write(CMD_BACKLIGHT_SET, BYTE_ON, 1'b1, 2);
        setter_write(CMD_BUZZER_SET, BUZZ_PULSE_REQ, 1'b1, 2);
        read_back(CMD_SLOT7_ALIAS, 4);
        send_op(OP_WRITE_ADDR, 8'h00);
        send_op(OP_DATA, CMD_HEATER_READ);
        repeat (3)
        begin
            e = make_event(OP_READ, 8'hFF);
            e.heater_pin_level = 1'b1;
            send(e);
        end
        send_op(OP_BUS_ERROR, 8'h00);
        send_op(OP_SPARE, 8'hFF);
        // The heater overrun left the pointer idle, so this zero byte is a command.
        send_op(OP_DATA, BYTE_OFF);
    endtask

    // Mostly well-formed transactions with random content; the rest is slot loads,
    // bus errors and stray events of any op. Now and then the sender waits for
    // every outstanding result.
    task automatic random_transaction();
        int   pick;
        evt_t e;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        if (pick < 35)
        begin
            setter_write(($urandom_range(0, 7) == 0) ? 8'($urandom) : setter_code(),
                         data_choice(), $urandom_range(0, 7) != 0,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 2);
            // Reading a setter returns its CRC and then closes the CRC.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_op(OP_READ, 8'($urandom));
        end
        else if (pick < 70)
            read_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, CMD_SLOT7_ALIAS)),
                      $urandom_range(1, 6));
        else if (pick < 82)
        begin
            e = make_event(OP_LOAD_SLOT, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
                e.slot_index = SLOT_BACKLIGHT;
            send(e);
        end
        else if (pick < 87)
            send_op(OP_BUS_ERROR, 8'($urandom));
        else if (pick < 98)
            send_op(3'($urandom_range(0, 7)), 8'($urandom));
        else
            drain();
    endtask

    task automatic run_random(int n);
        int start;
        start = items_sent;
        while (items_sent - start < n)
            random_transaction();
    endtask

    initial
    begin
        items_sent = 0;
        calm       = 1'b0;
        rst_n     <= 1'b0;
        evt_valid <= 1'b0;
        evt       <= make_event(OP_WRITE_ADDR, 8'h00);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit of 50 first.
        run_directed();
        run_random(450);

        // Highest limit: a storm of bus errors drives the counter into saturation
        // without ever reaching the reinit.
        write_error_limit(8'hFF);
        send_op(OP_WRITE_ADDR, 8'h00);
        repeat (270)
            send_op(OP_BUS_ERROR, 8'($urandom));

        // Reads of an unknown command count nothing, so the pointer runs all the way
        // round; the two bytes after it land at pointer 0 and 1 again.
        read_back(CMD_UNKNOWN, 256);
        send_op(OP_DATA, 8'h33);
        send_op(OP_DATA, 8'h44);
        run_random(150);

        // Lowest limit: every error reinitializes the slave.
        write_error_limit(8'h00);
        run_random(200);

        write_error_limit(8'($urandom_range(1, 20)));
        run_random(200);

        write_error_limit(ERROR_LIMIT_INIT);
        while (items_sent < ITEM_TARGET)
            random_transaction();

        drain();
        if (fails == 0)
            $display("tb_i2c_register_slave_crc8_core: PASS");
        else
            $display("tb_i2c_register_slave_crc8_core: FAIL");
        $finish;
    end

endmodule
